### src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define ZS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("zs check failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define ZS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("zs check failed");

`endif

### src/zs_pkg.sv
package zs_pkg;

  localparam int MAX_FEATURES = 32;
  localparam int MAX_SAMPLES  = 256;
  localparam int STORE_DEPTH  = MAX_FEATURES * MAX_SAMPLES;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int FEAT_W  = $clog2(MAX_FEATURES);
  localparam int DIV_W   = 72;
  localparam int DEN_W   = 32;
  localparam int CFG_W   = 9;

  // configuration register indexes
  localparam logic [1:0] CFG_FEATURE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_COUNT  = 2'd1;

endpackage

### src/zs_div.sv
module zs_div import zs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   quo_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             run_q, run_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[DIV_W-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      quo_d = '0;
    end else if (run_q) begin
      num_d = {num_q[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### src/zs_sqrt.sv
module zs_sqrt import zs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        run_q, run_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] v_q, v_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic        done_q, done_d;
  logic [63:0] trial;

  // digit-by-digit root, one result bit per cycle
  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    done_d = 1'b0;
    trial  = res_q + bit_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      v_d   = val_i;
      res_d = '0;
      bit_d = 64'h4000_0000_0000_0000;
    end else if (run_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 5'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

### src/feature_zscore_standardizer_top.sv
// Per-feature z-score standardizer (population standard deviation).
// Command channel: an item is taken at a rising edge with start high and busy
// low. kind_i = 0 loads value_i into the next slot of the data set (sample
// major); it gives no result and leaves busy low. Loads past
// feature_count * sample_count values are dropped; a load after drains opens
// a new data set. kind_i = 1 asks for the next standardized value.
// Results appear for one cycle with done_o high; the receiver cannot stall.
// A drain on an incomplete set gives status_o = 1 on the next cycle.
// The first drain on a full set runs the statistics pass through the value
// memory, per feature: a sum pass, a mean divide, a squared-deviation pass,
// a variance divide and a root. Each drain then runs the 72-step serial
// divider that scales (x - mean) by 1 / (stdev + 1).
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) are taken while
// idle and start a new data set. Reset clears positions and sets both sizes
// to 1; the memories are not cleared.
module feature_zscore_standardizer_top import zs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output logic               done_o,
  output logic signed [23:0] scaled_o,
  output logic [7:0]         sample_index_o,
  output logic [4:0]         feature_index_o,
  output logic signed [31:0] feature_mean_o,
  output logic [30:0]        feature_stdev_o,
  output logic               last_o,
  output logic               status_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SUM_RD   = 4'd1;
  localparam logic [3:0] ST_SUM_ACC  = 4'd2;
  localparam logic [3:0] ST_MEAN_GO  = 4'd3;
  localparam logic [3:0] ST_MEAN_DIV = 4'd4;
  localparam logic [3:0] ST_SQ_RD    = 4'd5;
  localparam logic [3:0] ST_SQ_ABS   = 4'd6;
  localparam logic [3:0] ST_SQ_MUL   = 4'd7;
  localparam logic [3:0] ST_SQ_ACC   = 4'd8;
  localparam logic [3:0] ST_VAR_GO   = 4'd9;
  localparam logic [3:0] ST_VAR_DIV  = 4'd10;
  localparam logic [3:0] ST_SQRT     = 4'd11;
  localparam logic [3:0] ST_DR_RD    = 4'd12;
  localparam logic [3:0] ST_DR_CALC  = 4'd13;
  localparam logic [3:0] ST_DR_DIV   = 4'd14;

  localparam int POS_W = ADDR_W + 1;

  logic [3:0]        state_q, state_d;
  logic [5:0]        fcount_q, fcount_d;
  logic [8:0]        scount_q, scount_d;
  logic [5:0]        nf;
  logic [8:0]        ns;
  logic [POS_W-1:0]  total;

  logic [POS_W-1:0]  lp_q, lp_d;
  logic [POS_W-1:0]  lp_base;
  logic [ADDR_W-1:0] dp_q, dp_d;
  logic [7:0]        ds_q, ds_d;
  logic [FEAT_W-1:0] df_q, df_d;
  logic              ready_q, ready_d;

  logic [5:0]        sf_q, sf_d;
  logic [8:0]        ss_q, ss_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic signed [40:0] sum_q, sum_d;
  logic [71:0]       acc_q, acc_d;
  logic [31:0]       mean_q, mean_d;
  logic [31:0]       a_q, a_d;
  logic [63:0]       sq_q, sq_d;

  logic              done_q, done_d;
  logic [23:0]       scaled_q, scaled_d;
  logic [7:0]        sidx_q, sidx_d;
  logic [4:0]        fidx_q, fidx_d;
  logic [31:0]       omean_q, omean_d;
  logic [30:0]       osd_q, osd_d;
  logic              last_q, last_d;
  logic              status_q, status_d;
  logic              neg_q, neg_d;

  logic [31:0]       vmem [STORE_DEPTH];
  logic [31:0]       vrd_q;
  logic              vwe;
  logic [ADDR_W-1:0] vaddr;
  logic [62:0]       smem [MAX_FEATURES];
  logic [62:0]       srd_q;
  logic              swe;

  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_num, div_quo;
  logic [DEN_W-1:0]  div_den;
  logic              sqrt_done;
  logic [31:0]       root;

  logic              accept;
  logic [32:0]       diff;
  logic [31:0]       mag;
  logic [39:0]       sum_mag;
  logic [32:0]       mq;
  logic [31:0]       sd_den;
  logic              is_last;

  assign nf    = (fcount_q == 6'd0) ? 6'd1 :
                 (fcount_q > 6'(MAX_FEATURES)) ? 6'(MAX_FEATURES) : fcount_q;
  assign ns    = (scount_q == 9'd0) ? 9'd1 :
                 (scount_q > 9'(MAX_SAMPLES)) ? 9'(MAX_SAMPLES) : scount_q;
  assign total = POS_W'(nf) * POS_W'(ns);

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign lp_base = ready_q ? '0 : lp_q;
  assign vwe     = accept && !kind_i && (lp_base < total);
  assign vaddr   = (state_q == ST_DR_RD) ? dp_q : addr_q;
  assign swe     = (state_q == ST_SQRT) && sqrt_done;

  assign sum_mag = sum_q[40] ? 40'(-sum_q) : sum_q[39:0];
  assign sd_den  = {1'b0, srd_q[30:0]} + 32'd1;
  assign is_last = ({1'b0, dp_q} + POS_W'(1)) == total;

  always_comb begin
    diff = 33'({vrd_q[31], vrd_q}) - 33'({mean_q[31], mean_q});
    if (state_q == ST_DR_CALC) begin
      diff = 33'({vrd_q[31], vrd_q}) - 33'({srd_q[62], srd_q[62:31]});
    end
    mag = diff[32] ? 32'(-diff) : diff[31:0];
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DEN_W'(ns);
    case (state_q)
      ST_MEAN_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(sum_mag) + DIV_W'(ns >> 1);
      end
      ST_VAR_GO: begin
        div_start = 1'b1;
        div_num   = acc_q;
      end
      ST_DR_CALC: begin
        div_start = 1'b1;
        div_num   = DIV_W'({mag, 16'd0}) + DIV_W'(sd_den >> 1);
        div_den   = sd_den;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    fcount_d = fcount_q;
    scount_d = scount_q;
    lp_d     = lp_q;
    dp_d     = dp_q;
    ds_d     = ds_q;
    df_d     = df_q;
    ready_d  = ready_q;
    sf_d     = sf_q;
    ss_d     = ss_q;
    addr_d   = addr_q;
    sum_d    = sum_q;
    acc_d    = acc_q;
    mean_d   = mean_q;
    a_d      = a_q;
    sq_d     = sq_q;
    neg_d    = neg_q;
    done_d   = 1'b0;
    scaled_d = scaled_q;
    sidx_d   = sidx_q;
    fidx_d   = fidx_q;
    omean_d  = omean_q;
    osd_d    = osd_q;
    last_d   = last_q;
    status_d = status_q;
    mq       = '0;

    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i && (cfg_index_i == CFG_FEATURE_COUNT ||
                         cfg_index_i == CFG_SAMPLE_COUNT)) begin
          if (cfg_index_i == CFG_FEATURE_COUNT) begin
            fcount_d = cfg_wdata_i[5:0];
          end else begin
            scount_d = cfg_wdata_i;
          end
          lp_d    = '0;
          dp_d    = '0;
          ds_d    = '0;
          df_d    = '0;
          ready_d = 1'b0;
        end else if (accept && !kind_i) begin
          if (ready_q) begin
            dp_d    = '0;
            ds_d    = '0;
            df_d    = '0;
            ready_d = 1'b0;
          end
          lp_d = vwe ? lp_base + 1'b1 : lp_base;
        end else if (accept) begin
          if (lp_q < total) begin
            done_d   = 1'b1;
            status_d = 1'b1;
            scaled_d = '0;
            sidx_d   = '0;
            fidx_d   = '0;
            omean_d  = '0;
            osd_d    = '0;
            last_d   = 1'b0;
          end else if (!ready_q) begin
            sf_d    = '0;
            ss_d    = '0;
            addr_d  = '0;
            sum_d   = '0;
            acc_d   = '0;
            state_d = ST_SUM_RD;
          end else begin
            state_d = ST_DR_RD;
          end
        end
      end
      ST_SUM_RD: state_d = ST_SUM_ACC;
      ST_SUM_ACC: begin
        sum_d  = sum_q + 41'(signed'(vrd_q));
        addr_d = addr_q + ADDR_W'(nf);
        ss_d   = ss_q + 1'b1;
        state_d = (ss_q + 1'b1 == ns) ? ST_MEAN_GO : ST_SUM_RD;
      end
      ST_MEAN_GO: state_d = ST_MEAN_DIV;
      ST_MEAN_DIV: begin
        if (div_done) begin
          mq      = div_quo[32:0];
          mean_d  = sum_q[40] ? 32'(-mq) : mq[31:0];
          ss_d    = '0;
          addr_d  = ADDR_W'(sf_q);
          state_d = ST_SQ_RD;
        end
      end
      ST_SQ_RD:  state_d = ST_SQ_ABS;
      ST_SQ_ABS: begin
        a_d     = mag;
        state_d = ST_SQ_MUL;
      end
      ST_SQ_MUL: begin
        sq_d    = a_q * a_q;
        state_d = ST_SQ_ACC;
      end
      ST_SQ_ACC: begin
        acc_d  = acc_q + 72'(sq_q);
        addr_d = addr_q + ADDR_W'(nf);
        ss_d   = ss_q + 1'b1;
        state_d = (ss_q + 1'b1 == ns) ? ST_VAR_GO : ST_SQ_RD;
      end
      ST_VAR_GO:  state_d = ST_VAR_DIV;
      ST_VAR_DIV: begin
        if (div_done) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          // advance to the next feature, or finish the pass
          sf_d   = sf_q + 1'b1;
          ss_d   = '0;
          addr_d = ADDR_W'(sf_q + 1'b1);
          sum_d  = '0;
          acc_d  = '0;
          if (sf_q + 1'b1 == nf) begin
            ready_d = 1'b1;
            dp_d    = '0;
            ds_d    = '0;
            df_d    = '0;
            state_d = ST_DR_RD;
          end else begin
            state_d = ST_SUM_RD;
          end
        end
      end
      ST_DR_RD: state_d = ST_DR_CALC;
      ST_DR_CALC: begin
        neg_d   = diff[32];
        state_d = ST_DR_DIV;
      end
      ST_DR_DIV: begin
        if (div_done) begin
          if (neg_q) begin
            scaled_d = (div_quo >= 72'h80_0000) ? 24'h80_0000 : 24'(-div_quo[23:0]);
          end else begin
            scaled_d = (div_quo >= 72'h7F_FFFF) ? 24'h7F_FFFF : div_quo[23:0];
          end
          done_d   = 1'b1;
          status_d = 1'b0;
          sidx_d   = ds_q;
          fidx_d   = df_q;
          omean_d  = srd_q[62:31];
          osd_d    = srd_q[30:0];
          last_d   = is_last;
          if (is_last) begin
            dp_d = '0;
            ds_d = '0;
            df_d = '0;
          end else begin
            dp_d = dp_q + 1'b1;
            if (6'(df_q) + 6'd1 == nf) begin
              df_d = '0;
              ds_d = ds_q + 1'b1;
            end else begin
              df_d = df_q + 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fcount_q <= 6'd1;
      scount_q <= 9'd1;
      lp_q     <= '0;
      dp_q     <= '0;
      ds_q     <= '0;
      df_q     <= '0;
      ready_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fcount_q <= fcount_d;
      scount_q <= scount_d;
      lp_q     <= lp_d;
      dp_q     <= dp_d;
      ds_q     <= ds_d;
      df_q     <= df_d;
      ready_q  <= ready_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sf_q     <= sf_d;
    ss_q     <= ss_d;
    addr_q   <= addr_d;
    sum_q    <= sum_d;
    acc_q    <= acc_d;
    mean_q   <= mean_d;
    a_q      <= a_d;
    sq_q     <= sq_d;
    neg_q    <= neg_d;
    scaled_q <= scaled_d;
    sidx_q   <= sidx_d;
    fidx_q   <= fidx_d;
    omean_q  <= omean_d;
    osd_q    <= osd_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  // value memory: one write port for loads, one registered read port
  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[lp_base[ADDR_W-1:0]] <= value_i;
    end
    vrd_q <= vmem[vaddr];
  end

  // statistics memory: {mean, stdev} per feature
  always_ff @(posedge clk_i) begin
    if (swe) begin
      smem[sf_q[FEAT_W-1:0]] <= {mean_q, (root[31] ? 31'h7FFF_FFFF : root[30:0])};
    end
    srd_q <= smem[df_q];
  end

  zs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  zs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == ST_VAR_DIV) && div_done),
    .val_i   (div_quo[63:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign done_o          = done_q;
  assign scaled_o        = scaled_q;
  assign sample_index_o  = sidx_q;
  assign feature_index_o = fidx_q;
  assign feature_mean_o  = omean_q;
  assign feature_stdev_o = osd_q;
  assign last_o          = last_q;
  assign status_o        = status_q;

endmodule

### src/zs_checker.sv
`include "assert_macros.svh"

module zs_checker import zs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               kind_i,
  input logic               done_o,
  input logic signed [23:0] scaled_o,
  input logic signed [31:0] feature_mean_o,
  input logic [30:0]        feature_stdev_o,
  input logic               last_o,
  input logic               status_o
);

  // a load transaction never produces a result
  `ZS_ASSERT_NEXT(a_load_silent, start && !busy && !kind_i, !done_o)

  // a drain transaction, unless a configuration write wins, either answers at once or starts work
  `ZS_ASSERT_NEXT(a_drain_moves, start && !busy && kind_i, done_o || busy)

  // finished work always ends in a result
  `ZS_ASSERT_NOW(a_busy_ends_done, !busy && $past(busy), done_o)

  // an error result carries zero fields
  `ZS_ASSERT_NOW(a_error_zero, done_o && status_o,
                 scaled_o == 0 && feature_mean_o == 0 && feature_stdev_o == 0 && !last_o)

endmodule

bind feature_zscore_standardizer_top zs_checker u_zs_checker (.*);
